// ----- hw/rtl/priority_resize_blocker_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the priority resize blocker
// Shared concurrent-assertion forms, clocked on clk and quiet during reset.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_RESIZE_BLOCKER_CORE_ASSERT_SVH
`define PRIORITY_RESIZE_BLOCKER_CORE_ASSERT_SVH

// same-cycle implication
`define PRB_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PRB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/prb_pkg.sv -----
// ---------------------------------------------------------------------------
// prb_pkg
// Request and response types and register indexes of the resize blocker.
// ---------------------------------------------------------------------------
package prb_pkg;

	localparam int STAMP_W = 48;
	localparam int DUR_W   = 32;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOW_DUR   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_DUR  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STALL_LVL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF    = 2'd3;

	typedef struct packed {
		logic                kind;
		logic [2:0]          priority_level;
		logic signed [47:0]  size_delta;
		logic [46:0]         current_target_bytes;
		logic [47:0]         now_time;
	} req_t;

	typedef struct packed {
		logic signed [47:0]  granted_delta;
		logic                was_blocked;
		logic signed [3:0]   unblocked_limit;
	} rsp_t;

endpackage

// ----- hw/rtl/priority_resize_blocker_core.sv -----
// ---------------------------------------------------------------------------
// priority_resize_blocker_core
// Per-level inflate/deflate blockers that gate balloon resize requests.
// ---------------------------------------------------------------------------
// Usage:
//   Pulse start with a request on req while busy is low; the request is
//   taken at that edge and busy rises. One response appears on rsp with
//   done high for exactly one cycle; busy is low again in that same cycle,
//   so the next start may be given there.
//   Resize request: one stamp table is walked between accept and done, one
//   entry of it read per cycle at the shared scan index.
//   Stall event: the inflate table is walked, the new deflate stamp is
//   written, and then the deflate table is walked.
//   Configuration: cfg_we/cfg_index/cfg_wdata, written only while idle by
//   the user; the block does not enforce it. Reset clears all blockers
//   (per-entry valid bits) and loads the register defaults; no clearing
//   pass is needed. The receiver cannot stall; rsp holds until the next done.
// ---------------------------------------------------------------------------
module priority_resize_blocker_core #(
	parameter int NUM_LEVELS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  prb_pkg::req_t                     req,
	output logic                              done,
	output prb_pkg::rsp_t                     rsp,
	input  logic                              cfg_we,
	input  logic [prb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [prb_pkg::CFG_W-1:0]         cfg_wdata
);

	localparam int LW   = $clog2(NUM_LEVELS);
	localparam int LIMW = LW + 1;
	localparam logic [LW-1:0] LAST_LVL = LW'(NUM_LEVELS - 1);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN1  = 3'd1;
	localparam logic [2:0] ST_DRAIN1 = 3'd2;
	localparam logic [2:0] ST_RECORD = 3'd3;
	localparam logic [2:0] ST_SCAN2  = 3'd4;
	localparam logic [2:0] ST_DRAIN2 = 3'd5;
	localparam logic [2:0] ST_FINISH = 3'd6;

	logic [2:0] state_q;

	// configuration
	logic [prb_pkg::DUR_W-1:0] low_dur_q, high_dur_q;
	logic [2:0]                stall_lvl_q, cutoff_q;

	// latched request
	logic                         stall_q;
	logic                         defl_q;
	logic [LW-1:0]                lvl_q;
	logic signed [47:0]           delta_q;
	logic [46:0]                  tgt_q;
	logic [prb_pkg::STAMP_W-1:0]  now_q;

	// stamp memories and valid bits
	logic [prb_pkg::STAMP_W-1:0] infl_mem [NUM_LEVELS];
	logic [prb_pkg::STAMP_W-1:0] defl_mem [NUM_LEVELS];
	logic [NUM_LEVELS-1:0]       infl_vld_q, defl_vld_q;

	// scan
	logic [LW-1:0]               cnt_q;
	logic                        rd_act;
	logic                        rd_act_s1;
	logic                        rd_infl_s1;
	logic [LW-1:0]               rd_idx_s1;
	logic                        rd_vld_s1;
	logic [prb_pkg::STAMP_W-1:0] infl_rd_s1, defl_rd_s1;
	logic [prb_pkg::STAMP_W-1:0] rd_dat;
	logic                        hit;
	logic                        found_q;
	logic [LW-1:0]               idx_q;
	logic signed [LIMW-1:0]      lim_cur;

	// record
	logic                        wr_en;
	logic [LW-1:0]               wr_lvl;
	logic [prb_pkg::STAMP_W-1:0] stamp;
	logic [prb_pkg::STAMP_W:0]   stamp_sum;
	logic [prb_pkg::DUR_W-1:0]   dur;
	logic                        blk;
	logic signed [47:0]          gnt;
	logic [47:0]                 mag;
	logic [47:0]                 mag_min;

	// result holding
	logic signed [47:0]          gnt_q;
	logic                        blk_q;
	logic signed [LIMW-1:0]      lim_q;
	logic signed [LIMW-1:0]      lim_fin;
	logic signed [3:0]           lim_out;
	logic                        done_q;
	prb_pkg::rsp_t               rsp_q;

	logic [LW-1:0]               req_lvl;
	logic [LW-1:0]               stall_lvl;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	assign req_lvl   = (int'(req.priority_level) >= NUM_LEVELS) ? LAST_LVL
	                 : LW'(req.priority_level);
	assign stall_lvl = (int'(stall_lvl_q) >= NUM_LEVELS) ? LAST_LVL : LW'(stall_lvl_q);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_dur_q   <= '0;
			high_dur_q  <= '0;
			stall_lvl_q <= 3'd1;
			cutoff_q    <= 3'd4;
		end else if (cfg_we) begin
			case (cfg_index)
				prb_pkg::CFG_LOW_DUR:   low_dur_q   <= cfg_wdata;
				prb_pkg::CFG_HIGH_DUR:  high_dur_q  <= cfg_wdata;
				prb_pkg::CFG_STALL_LVL: stall_lvl_q <= cfg_wdata[2:0];
				prb_pkg::CFG_CUTOFF:    cutoff_q    <= cfg_wdata[2:0];
				default: ;
			endcase
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			stall_q <= req.kind;
			defl_q  <= req.kind ? 1'b1 : req.size_delta[47];
			lvl_q   <= req.kind ? stall_lvl : req_lvl;
			delta_q <= req.size_delta;
			tgt_q   <= req.current_target_bytes;
			now_q   <= req.now_time;
		end
	end

	// memory read port and write-back
	assign rd_act = (state_q == ST_SCAN1) || (state_q == ST_SCAN2);

	always_ff @(posedge clk) begin
		infl_rd_s1 <= infl_mem[cnt_q];
		defl_rd_s1 <= defl_mem[cnt_q];
		if (wr_en && !defl_q) begin
			infl_mem[wr_lvl] <= stamp;
		end
		if (wr_en && defl_q) begin
			defl_mem[wr_lvl] <= stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_act_s1  <= 1'b0;
			rd_infl_s1 <= 1'b0;
			rd_idx_s1  <= '0;
			rd_vld_s1  <= 1'b0;
		end else begin
			rd_act_s1  <= rd_act;
			rd_infl_s1 <= (state_q == ST_SCAN1) && defl_q;
			rd_idx_s1  <= cnt_q;
			rd_vld_s1  <= ((state_q == ST_SCAN1) && defl_q) ? infl_vld_q[cnt_q]
			                                                : defl_vld_q[cnt_q];
		end
	end

	assign rd_dat = rd_infl_s1 ? infl_rd_s1 : defl_rd_s1;
	assign hit    = rd_act_s1 && rd_vld_s1 && (rd_dat != '0) && (rd_dat >= now_q);

	assign lim_cur = found_q ? ($signed({1'b0, idx_q}) - LIMW'(1)) : LIMW'(NUM_LEVELS - 1);

	// record: cap, stamp, clear more urgent levels
	always_comb begin
		int lvl_i;
		int lim_i;
		int stl_i;
		lvl_i = int'(lvl_q);
		lim_i = int'(lim_cur);
		stl_i = int'(stall_lvl_q);

		wr_en     = (state_q == ST_RECORD) && (lvl_q != LAST_LVL);
		wr_lvl    = ((lvl_i < lim_i) && (lvl_i > stl_i)) ? lim_cur[LW-1:0] : lvl_q;
		dur       = (int'(lvl_q) >= int'(cutoff_q)) ? low_dur_q : high_dur_q;
		stamp_sum = {1'b0, now_q} + (prb_pkg::STAMP_W+1)'(dur);
		stamp     = stamp_sum[prb_pkg::STAMP_W] ? '1 : stamp_sum[prb_pkg::STAMP_W-1:0];

		mag     = 48'(~delta_q + 48'd1);
		mag_min = (mag > {1'b0, tgt_q}) ? {1'b0, tgt_q} : mag;
		blk     = !stall_q && (lvl_i > lim_i);
		if (stall_q || blk) begin
			gnt = '0;
		end else if (defl_q) begin
			gnt = $signed(48'(~mag_min + 48'd1));
		end else begin
			gnt = delta_q;
		end

		lim_fin = stall_q ? lim_cur : lim_q;
		lim_out = (int'(lim_fin) > 7) ? 4'sd7 : 4'(lim_fin);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RECORD) begin
			gnt_q <= gnt;
			blk_q <= blk;
			lim_q <= lim_cur;
		end
		if (state_q == ST_FINISH) begin
			rsp_q.granted_delta   <= gnt_q;
			rsp_q.was_blocked     <= blk_q;
			rsp_q.unblocked_limit <= lim_out;
		end
	end

	// sequencer, scan bookkeeping, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			found_q    <= 1'b0;
			idx_q      <= '0;
			done_q     <= 1'b0;
			infl_vld_q <= '0;
			defl_vld_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (hit && !found_q) begin
				found_q <= 1'b1;
				idx_q   <= rd_idx_s1;
			end
			if (wr_en) begin
				for (int i = 0; i < NUM_LEVELS; i++) begin
					if (i < int'(wr_lvl)) begin
						if (defl_q) defl_vld_q[i] <= 1'b0;
						else        infl_vld_q[i] <= 1'b0;
					end else if (i == int'(wr_lvl)) begin
						if (defl_q) defl_vld_q[i] <= 1'b1;
						else        infl_vld_q[i] <= 1'b1;
					end
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_SCAN1;
						cnt_q   <= '0;
						found_q <= 1'b0;
					end
				end
				ST_SCAN1: begin
					cnt_q <= cnt_q + LW'(1);
					if (cnt_q == LAST_LVL) state_q <= ST_DRAIN1;
				end
				ST_DRAIN1: state_q <= ST_RECORD;
				ST_RECORD: begin
					cnt_q   <= '0;
					found_q <= 1'b0;
					state_q <= stall_q ? ST_SCAN2 : ST_FINISH;
				end
				ST_SCAN2: begin
					cnt_q <= cnt_q + LW'(1);
					if (cnt_q == LAST_LVL) state_q <= ST_DRAIN2;
				end
				ST_DRAIN2: state_q <= ST_FINISH;
				ST_FINISH: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`include "priority_resize_blocker_core_assert.svh"

	`PRB_ASSERT_SAME(a_done_idle, done_q, state_q == ST_IDLE, "response while busy")
	`PRB_ASSERT_NEXT(a_start_busy, start && !busy, state_q == ST_SCAN1, "request not taken")
	`PRB_ASSERT_SAME(a_blk_zero, done_q && rsp_q.was_blocked, rsp_q.granted_delta == '0,
		"blocked request granted")
	`PRB_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "response repeated")

endmodule

// ----- tb/sv/tb_priority_resize_blocker_core.sv -----
// ---------------------------------------------------------------------------
// tb_priority_resize_blocker_core
// Self-checking bench for the resize blocker core: drives resize and stall
// requests in random bursts, predicts each response from a local copy of the
// inflate/deflate block-until tables and compares every field on done.
// ---------------------------------------------------------------------------
module tb_priority_resize_blocker_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int   NUM_LEVELS  = 8;
	localparam logic KIND_RESIZE = 1'b0;
	localparam logic KIND_STALL  = 1'b1;

	logic                          clk;
	logic                          arst_n;
	logic                          start;
	logic                          busy;
	prb_pkg::req_t                 req;
	logic                          done;
	prb_pkg::rsp_t                 rsp;
	logic                          cfg_we;
	logic [prb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [prb_pkg::CFG_W-1:0]     cfg_wdata;

	priority_resize_blocker_core #(
		.NUM_LEVELS(NUM_LEVELS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// predictor state
	logic [47:0] infl_until [NUM_LEVELS];
	logic [47:0] defl_until [NUM_LEVELS];
	logic [31:0] dur_low;
	logic [31:0] dur_high;
	int          stall_lvl;
	int          cutoff_lvl;

	prb_pkg::rsp_t pending_grants [$];
	int            fail_count;
	int            burst_left;
	int            gap_max;
	logic [47:0]   clock_now;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int limit_of(bit defl, logic [47:0] now);
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (defl) begin
				if (infl_until[i] != '0 && infl_until[i] >= now) return i - 1;
			end else begin
				if (defl_until[i] != '0 && defl_until[i] >= now) return i - 1;
			end
		end
		return NUM_LEVELS - 1;
	endfunction

	function automatic void stamp_blocker(bit defl, int lvl, logic [47:0] now);
		logic [31:0] dur;
		logic [48:0] sum;
		logic [47:0] stamp;
		int          lim;
		int          lv;
		lv = lvl;
		if (lv == NUM_LEVELS - 1) return;
		dur = (lv >= cutoff_lvl) ? dur_low : dur_high;
		lim = limit_of(defl, now);
		if (lv < lim && lv > stall_lvl) lv = lim;
		sum = {1'b0, now} + {17'b0, dur};
		stamp = sum[48] ? '1 : sum[47:0];
		for (int i = 0; i < NUM_LEVELS; i++) begin
			if (defl) begin
				if (i == lv) defl_until[i] = stamp;
				else if (i < lv) defl_until[i] = '0;
			end else begin
				if (i == lv) infl_until[i] = stamp;
				else if (i < lv) infl_until[i] = '0;
			end
		end
	endfunction

	function automatic prb_pkg::rsp_t predict_grant(prb_pkg::req_t r);
		prb_pkg::rsp_t o;
		longint        delta;
		longint        mag;
		longint        tgt;
		bit            defl;
		int            lv;
		int            lim;
		o.granted_delta = '0;
		o.was_blocked   = 1'b0;
		if (r.kind == KIND_STALL) begin
			stamp_blocker(1'b1, stall_lvl, r.now_time);
			lim = limit_of(1'b0, r.now_time);
		end else begin
			lv    = int'(r.priority_level);
			delta = longint'($signed(r.size_delta));
			defl  = delta < 0;
			stamp_blocker(defl, lv, r.now_time);
			lim = limit_of(defl, r.now_time);
			if (lv > lim) begin
				o.was_blocked = 1'b1;
			end else if (defl) begin
				mag = -delta;
				tgt = longint'({17'b0, r.current_target_bytes});
				if (mag > tgt) mag = tgt;
				o.granted_delta = 48'(-mag);
			end else begin
				o.granted_delta = 48'(delta);
			end
		end
		if (lim > 7) lim = 7;
		o.unblocked_limit = 4'(lim);
		return o;
	endfunction

	function automatic prb_pkg::req_t mk_req(logic kind, int lvl, longint delta,
			longint tgt, logic [47:0] now);
		prb_pkg::req_t r;
		r.kind                 = kind;
		r.priority_level       = 3'(lvl);
		r.size_delta           = 48'(delta);
		r.current_target_bytes = 47'(tgt);
		r.now_time             = now;
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic prb_pkg::req_t rand_item();
		prb_pkg::req_t r;
		int            sel;
		longint        mag;
		sel = $urandom_range(0, 99);
		r.kind           = ($urandom_range(0, 9) == 0) ? KIND_STALL : KIND_RESIZE;
		r.priority_level = 3'($urandom_range(0, 7));
		if (sel < 85) begin
			clock_now = clock_now + 48'($urandom_range(0, 40));
			r.now_time = clock_now;
			mag = longint'($urandom_range(0, 1 << 20));
			r.size_delta = $urandom_range(0, 1) ? 48'(-mag) : 48'(mag);
			r.current_target_bytes = 47'($urandom_range(0, 1 << 21));
		end else begin
			r.now_time             = rand48();
			r.size_delta           = rand48();
			r.current_target_bytes = 47'(rand48());
		end
		return r;
	endfunction

	task automatic send_item(prb_pkg::req_t r);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				start = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		burst_left--;
		start = 1'b1;
		req   = r;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_grants.push_back(predict_grant(r));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		start = 1'b0;
		while (pending_grants.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [prb_pkg::CFG_IDX_W-1:0] idx,
			logic [prb_pkg::CFG_W-1:0] data);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			prb_pkg::CFG_LOW_DUR:   dur_low    = data;
			prb_pkg::CFG_HIGH_DUR:  dur_high   = data;
			prb_pkg::CFG_STALL_LVL: stall_lvl  = int'(data[2:0]);
			prb_pkg::CFG_CUTOFF:    cutoff_lvl = int'(data[2:0]);
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] lo, logic [31:0] hi, logic [31:0] st,
			logic [31:0] cut);
		wait_idle();
		write_reg(prb_pkg::CFG_LOW_DUR, lo);
		write_reg(prb_pkg::CFG_HIGH_DUR, hi);
		write_reg(prb_pkg::CFG_STALL_LVL, st);
		write_reg(prb_pkg::CFG_CUTOFF, cut);
	endtask

	always @(posedge clk) begin : chk
		prb_pkg::rsp_t exp_rsp;
		if (arst_n && done) begin
			if (pending_grants.size() == 0) begin
				$error("response with no request outstanding");
				fail_count++;
			end else begin
				exp_rsp = pending_grants.pop_front();
				if (rsp.granted_delta !== exp_rsp.granted_delta) begin
					$error("granted_delta: expected %0d, actual %0d",
						exp_rsp.granted_delta, rsp.granted_delta);
					fail_count++;
				end
				if (rsp.was_blocked !== exp_rsp.was_blocked) begin
					$error("was_blocked: expected %0d, actual %0d",
						exp_rsp.was_blocked, rsp.was_blocked);
					fail_count++;
				end
				if (rsp.unblocked_limit !== exp_rsp.unblocked_limit) begin
					$error("unblocked_limit: expected %0d, actual %0d",
						exp_rsp.unblocked_limit, rsp.unblocked_limit);
					fail_count++;
				end
			end
		end
	end

	// reset config: zero durations block only at the very same tick
	task automatic test_defaults();
		send_item(mk_req(KIND_RESIZE, 3, 1000, 0, 100));
		send_item(mk_req(KIND_RESIZE, 5, -500, 200, 100));
		send_item(mk_req(KIND_RESIZE, 2, -500, 200, 100));
		send_item(mk_req(KIND_RESIZE, 7, 42, 0, 101));
		send_item(mk_req(KIND_RESIZE, 6, -3, 1000, 101));
	endtask

	// a stamp of zero never blocks, even at tick zero
	task automatic test_zero_stamp();
		set_config(0, 0, 1, 4);
		send_item(mk_req(KIND_RESIZE, 0, 10, 0, 0));
		send_item(mk_req(KIND_RESIZE, 0, -10, 5, 0));
		send_item(mk_req(KIND_RESIZE, 3, 10, 0, 0));
	endtask

	task automatic test_field_extremes();
		set_config(50, 50, 32'hFFFF_FFFF, 0);
		send_item(mk_req(KIND_RESIZE, 0, 64'sh7FFF_FFFF_FFFF, 0, 1000));
		send_item(mk_req(KIND_RESIZE, 0, -64'sh8000_0000_0000, 64'h7FFF_FFFF_FFFF, 1000));
		send_item(mk_req(KIND_RESIZE, 0, -64'sh8000_0000_0000, 0, 2000));
		send_item(mk_req(KIND_RESIZE, 1, -1, 0, 2000));
		send_item(mk_req(KIND_RESIZE, 7, 0, 64'h7FFF_FFFF_FFFF, 3000));
		send_item(mk_req(KIND_RESIZE, 4, -1, 64'h7FFF_FFFF_FFFF, 3000));
	endtask

	// now + duration runs past the top of the stamp range
	task automatic test_saturation();
		set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, 7);
		send_item(mk_req(KIND_RESIZE, 1, 77, 0, 48'hFFFF_FFFF_FFF0));
		send_item(mk_req(KIND_RESIZE, 6, -77, 100, 48'hFFFF_FFFF_FFFF));
		send_item(mk_req(KIND_RESIZE, 0, -77, 100, 48'hFFFF_FFFF_FFFF));
		send_item(mk_req(KIND_RESIZE, 5, 77, 100, 48'hFFFF_FFFF_FFFF));
	endtask

	// stall fields other than now are don't-care
	task automatic test_stall_events();
		set_config(20, 40, 0, 4);
		send_item(mk_req(KIND_STALL, 7, -64'sh8000_0000_0000, 64'h7FFF_FFFF_FFFF, 500));
		send_item(mk_req(KIND_RESIZE, 2, 900, 0, 505));
		set_config(20, 40, 3, 2);
		send_item(mk_req(KIND_STALL, 0, 64'sh7FFF_FFFF_FFFF, 0, 600));
		send_item(mk_req(KIND_RESIZE, 3, 900, 0, 610));
		send_item(mk_req(KIND_RESIZE, 1, 900, 0, 610));
		set_config(20, 40, 7, 2);
		send_item(mk_req(KIND_STALL, 5, 12, 34, 700));
	endtask

	task automatic test_random_traffic();
		logic [31:0] lo;
		logic [31:0] hi;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(0, 0, 0, 0);
				1: set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7, 7);
				default: begin
					lo = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200);
					hi = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200);
					set_config(lo, hi, $urandom, $urandom);
				end
			endcase
			gap_max = (ph == 2) ? 0 : $urandom_range(5, 30);
			for (int n = 0; n < 230; n++) begin
				if (ph == 3 && n == 115) wait_idle();
				send_item(rand_item());
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		req        = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		fail_count = 0;
		burst_left = 0;
		gap_max    = 6;
		clock_now  = 48'd1;
		dur_low    = '0;
		dur_high   = '0;
		stall_lvl  = 1;
		cutoff_lvl = 4;
		for (int i = 0; i < NUM_LEVELS; i++) begin
			infl_until[i] = '0;
			defl_until[i] = '0;
		end
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_defaults();
		test_zero_stamp();
		test_field_extremes();
		test_saturation();
		test_stall_events();
		test_random_traffic();

		start = 1'b0;
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/prb_pkg.sv
hw/rtl/priority_resize_blocker_core.sv
tb/sv/tb_priority_resize_blocker_core.sv
